### rtl/constrained_motzkin_path_count_assert.svh
// Assertion macros shared by the constrained Motzkin path counter.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef CONSTRAINED_MOTZKIN_PATH_COUNT_ASSERT_SVH
`define CONSTRAINED_MOTZKIN_PATH_COUNT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CMPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CMPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/cmpc_pkg.sv
// Shared types and constants of the constrained Motzkin path counter.
// No dependencies.
package cmpc_pkg;

  localparam int CMPC_MAX_WIDTH = 28;
  localparam int LEN_W          = 5;
  localparam int MASK_BITS      = 28;
  localparam int POS_W          = 5;
  localparam int MASK_EXT       = 1 << POS_W;
  localparam int COUNT_W        = 64;

  typedef logic [COUNT_W-1:0] count_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             step;
    logic             capture;
    logic [POS_W-1:0] pos;
  } cmd_t;

endpackage

### rtl/constrained_motzkin_path_count.sv
// Top level of the constrained Motzkin path counter.
// Depends on cmpc_pkg, cmpc_ctrl and cmpc_datapath.
//
//  Channel | Handshake           | Word
//  --------+---------------------+----------------------------------------------
//  in      | in_valid/in_ready   | in_path_length, in_forced_mask, in_forced_value
//  out     | out_valid/out_ready | out_path_count
//
// An item is loaded, then stepped once per column of its path, then captured.
// Each step updates every height cell at once, one column per clock.
// Reset is synchronous, active low.
// A new word is accepted while the previous result waits in the output register;
// a run that ends while that register is still full holds until it is taken.
module constrained_motzkin_path_count #(
  parameter int MAX_WIDTH = cmpc_pkg::CMPC_MAX_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cmpc_pkg::LEN_W-1:0]     in_path_length,
  input  logic [cmpc_pkg::MASK_BITS-1:0] in_forced_mask,
  input  logic [cmpc_pkg::MASK_BITS-1:0] in_forced_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cmpc_pkg::COUNT_W-1:0]   out_path_count
);
  import cmpc_pkg::*;

  cmd_t cmd;

  // Sequencer and handshakes.
  cmpc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_path_length(in_path_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cmd           (cmd)
  );

  // Height cells and output register.
  cmpc_datapath #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .in_forced_mask (in_forced_mask),
    .in_forced_value(in_forced_value),
    .out_path_count (out_path_count)
  );

endmodule

### rtl/cmpc_ctrl.sv
// Controller of the constrained Motzkin path counter: handshakes and step sequencing.
// Depends on cmpc_pkg and the assertion macro header.
`include "constrained_motzkin_path_count_assert.svh"

module cmpc_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cmpc_pkg::LEN_W-1:0] in_path_length,
  output logic                      out_valid,
  input  logic                      out_ready,
  output cmpc_pkg::cmd_t            cmd
);
  import cmpc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [POS_W-1:0] step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  // The output register can take a new word if empty or emptied this cycle.
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // Next-state logic and command generation.
  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    step_nxt    = step_r;
    in_ready    = 1'b0;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.capture = 1'b0;
    cmd.pos     = step_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          len_nxt   = in_path_length;
          step_nxt  = '0;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (step_r == len_r) begin
          if (out_free) begin
            cmd.capture = 1'b1;
            state_nxt   = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end else begin
          cmd.step = 1'b1;
          step_nxt = step_r + POS_W'(1);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.capture = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output word flag: set on capture, cleared when the word is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `CMPC_ASSERT_NEXT(a_accept_starts_run, in_valid && in_ready, state_r == S_RUN, "accepted word did not start a run")
  `CMPC_ASSERT_SAME(a_step_within_len, state_r == S_RUN || state_r == S_HOLD, step_r <= len_r, "step counter passed the path length")
  `CMPC_ASSERT_SAME(a_capture_needs_room, cmd.capture, !out_valid_r || out_ready, "capture would overwrite a pending word")
  `CMPC_ASSERT_NEXT(a_capture_sets_valid, cmd.capture, out_valid_r, "captured word not presented")

endmodule

### rtl/cmpc_datapath.sv
// Datapath of the constrained Motzkin path counter: one cell per height, output register.
// Depends on cmpc_pkg.
module cmpc_datapath #(
  parameter int MAX_WIDTH = cmpc_pkg::CMPC_MAX_WIDTH
) (
  input  logic                          clk,
  input  cmpc_pkg::cmd_t                cmd,
  input  logic [cmpc_pkg::MASK_BITS-1:0] in_forced_mask,
  input  logic [cmpc_pkg::MASK_BITS-1:0] in_forced_value,
  output cmpc_pkg::count_t              out_path_count
);
  import cmpc_pkg::*;

  logic [MASK_BITS-1:0] mask_r;
  logic [MASK_BITS-1:0] val_r;
  logic [MASK_EXT-1:0]  mask_ext;
  logic [MASK_EXT-1:0]  val_ext;
  logic                 constrained;
  logic                 vertical;
  logic                 flat_en;
  logic                 vert_en;
  count_t               cell_r   [0:MAX_WIDTH];
  count_t               cell_nxt [0:MAX_WIDTH];
  count_t               path_count_r;

  // Step kind at the current position; positions past the mask are free.
  assign mask_ext    = {{(MASK_EXT - MASK_BITS){1'b0}}, mask_r};
  assign val_ext     = {{(MASK_EXT - MASK_BITS){1'b0}}, val_r};
  assign constrained = mask_ext[cmd.pos];
  assign vertical    = val_ext[cmd.pos];
  assign flat_en     = !constrained || !vertical;
  assign vert_en     = !constrained || vertical;

  // One cell per height: flat from itself, up from below, down from above.
  // An up move from the top height falls off the column.
  for (genvar h = 0; h <= MAX_WIDTH; h++) begin : g_cell
    count_t below;
    count_t above;
    if (h > 0) begin : g_below
      assign below = cell_r[h-1];
    end else begin : g_floor
      assign below = '0;
    end
    if (h < MAX_WIDTH) begin : g_above
      assign above = cell_r[h+1];
    end else begin : g_top
      assign above = '0;
    end
    assign cell_nxt[h] = (flat_en ? cell_r[h] : '0)
                       + (vert_en ? below : '0)
                       + (vert_en ? above : '0);

    always_ff @(posedge clk) begin
      if (cmd.load) begin
        cell_r[h] <= (h == 0) ? COUNT_W'(1) : '0;
      end else if (cmd.step) begin
        cell_r[h] <= cell_nxt[h];
      end
    end
  end

  // Step masks held for the whole item; result taken from height one.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mask_r <= in_forced_mask;
      val_r  <= in_forced_value;
    end
    if (cmd.capture) begin
      path_count_r <= cell_r[1];
    end
  end

  assign out_path_count = path_count_r;

endmodule

### tb/testbench.sv
// Self-checking testbench for the constrained Motzkin path counter.
// Depends on cmpc_pkg and constrained_motzkin_path_count; predicts every count itself.
module testbench;
  import cmpc_pkg::*;

  localparam int NUM_CELLS    = CMPC_MAX_WIDTH + 2;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 1950;

  // Scoreboard: predicts the path count of each accepted word and checks results in order.
  class path_count_scoreboard;
    count_t      expected_counts[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Column-by-column count of paths from height 0 that end at height 1.
    function count_t predict_count(logic [LEN_W-1:0] len, logic [MASK_BITS-1:0] fmask,
                                   logic [MASK_BITS-1:0] fval);
      count_t cells [NUM_CELLS];
      count_t next_cells [NUM_CELLS];
      count_t acc;
      bit     constrained;
      bit     vertical;
      foreach (cells[h]) cells[h] = '0;
      cells[0] = count_t'(1);
      for (int pos = 0; pos < int'(len); pos++) begin
        // Step positions past the mask width are never constrained.
        constrained = (pos < MASK_BITS) ? fmask[pos] : 1'b0;
        vertical    = (pos < MASK_BITS) ? fval[pos] : 1'b0;
        for (int h = 0; h <= CMPC_MAX_WIDTH; h++) begin
          acc = '0;
          if (!constrained || !vertical) acc += cells[h];
          if (!constrained || vertical) begin
            if (h > 0) acc += cells[h-1];
            acc += cells[h+1];
          end
          next_cells[h] = acc;
        end
        // The cell above the cap stays empty, so an up move from the top is dropped.
        next_cells[NUM_CELLS-1] = '0;
        cells = next_cells;
      end
      return cells[1];
    endfunction

    function void note_word(logic [LEN_W-1:0] len, logic [MASK_BITS-1:0] fmask,
                            logic [MASK_BITS-1:0] fval);
      expected_counts.insert(expected_counts.size(), predict_count(len, fmask, fval));
    endfunction

    function void check_count(count_t got);
      count_t want;
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected path_count %0d, expected none", $time, got);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        if (got !== want) begin
          $display("%0t: path_count mismatch: expected %0d, got %0d", $time, want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_counts.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [LEN_W-1:0]     in_path_length;
  logic [MASK_BITS-1:0] in_forced_mask;
  logic [MASK_BITS-1:0] in_forced_value;
  logic                 out_valid;
  logic                 out_ready;
  count_t               out_path_count;

  path_count_scoreboard sb = new();

  // Idle control shared between the sender and the receiver.
  bit tx_steady;
  bit rx_steady;
  int hold_requests;
  int hold_served;
  int rx_stall_left;

  constrained_motzkin_path_count uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_path_length  (in_path_length),
    .in_forced_mask  (in_forced_mask),
    .in_forced_value (in_forced_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_path_count  (out_path_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard limit on the run time.
  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

  // Gap lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 30);
  endfunction

  // Offer one word and hold it until it is accepted.
  task automatic send_word(logic [LEN_W-1:0] len, logic [MASK_BITS-1:0] fmask,
                           logic [MASK_BITS-1:0] fval);
    @(negedge clk);
    in_valid        <= 1'b1;
    in_path_length  <= len;
    in_forced_mask  <= fmask;
    in_forced_value <= fval;
    do @(posedge clk); while (!in_ready);
    sb.note_word(len, fmask, fval);
  endtask

  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // One random word: mostly lengths within the cap, masks from open to fully forced.
  task automatic send_random_word();
    logic [LEN_W-1:0]     len;
    logic [MASK_BITS-1:0] fmask;
    logic [MASK_BITS-1:0] fval;
    int                   r;
    r = $urandom_range(0, 99);
    if (r < 5) len = LEN_W'($urandom_range(29, 31));
    else if (r < 15) len = LEN_W'(CMPC_MAX_WIDTH);
    else if (r < 25) len = LEN_W'($urandom_range(0, 3));
    else len = LEN_W'($urandom_range(0, 27));
    fval = MASK_BITS'($urandom());
    case ($urandom_range(0, 4))
      0: fmask = '0;
      1: fmask = MASK_BITS'($urandom() & $urandom() & $urandom());
      2: fmask = MASK_BITS'($urandom());
      3: fmask = '1;
      default: begin
        fmask = MASK_BITS'($urandom());
        fval  = fmask ^ MASK_BITS'($urandom() & $urandom());
      end
    endcase
    send_word(len, fmask, fval);
    idle_input(tx_steady ? 0 : pick_gap());
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready     = 1'b0;
    rx_stall_left = 0;
    hold_served   = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_served) begin
        hold_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rx_steady) rx_stall_left = pick_gap();
      end
    end
  end

  // Check every result word as it is taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_count(out_path_count);
  end

  // Reset, directed words, then random phases.
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_path_length  = '0;
    in_forced_mask  = '0;
    in_forced_value = '0;
    tx_steady       = 1'b0;
    rx_steady       = 1'b0;
    hold_requests   = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero length, single steps free and forced, both forcing kinds at full length.
    send_word(5'd0, '0, '0);
    send_word(5'd0, '1, '1);
    send_word(5'd1, '0, '0);
    send_word(5'd1, 28'h1, 28'h0);
    send_word(5'd1, 28'h1, 28'h1);
    send_word(5'd2, '0, '0);
    send_word(5'd28, '0, '0);
    send_word(5'd28, '1, '0);
    send_word(5'd28, '1, '1);
    send_word(5'd28, '1, 28'h5555555);
    send_word(5'd28, '1, 28'hAAAAAAA);
    send_word(5'd28, 28'hAAAAAAA, 28'hFFFFFFF);
    // Lengths past the mask width: the extra steps are free.
    send_word(5'd29, '0, '0);
    send_word(5'd30, '1, '1);
    send_word(5'd31, '0, '1);
    send_word(5'd31, '1, '0);
    send_word(5'd31, '1, 28'hFFFFFFE);
    send_word(5'd27, 28'h8000001, 28'h8000001);
    idle_input(1);
    wait_drained();

    // Random idling on both sides.
    repeat (500) send_random_word();

    // Long receiver hold-off while the sender keeps offering words.
    tx_steady = 1'b1;
    hold_requests++;
    repeat (20) send_random_word();
    tx_steady = 1'b0;

    // Sender pause until everything has come back.
    idle_input(1);
    wait_drained();

    // No idling on either side.
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (400) send_random_word();
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    repeat (RANDOM_WORDS - 920) send_random_word();

    // Let the last results drain, then a few quiet cycles for strays.
    idle_input(1);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
